// ----- hdl/imu_uart_frame_parser_top_macros.svh -----
// assertion macros for the imu uart frame parser
// used by imu_uart_frame_parser_top; no other dependencies
`ifndef IMU_UART_FRAME_PARSER_TOP_MACROS_SVH
`define IMU_UART_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, quiet during reset
`define IMUFP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imufp assertion failed");
// next-cycle implication, active during reset
`define IMUFP_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("imufp assertion failed");
`else
`define IMUFP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define IMUFP_ASSERT_NEXT(lbl, clk, ante, cons)
`endif

`endif

// ----- hdl/imufp_pkg.sv -----
// shared constants and types for the imu uart frame parser
// no dependencies; used by every file but the assertion macros header
package imufp_pkg;

   // frame bytes
   localparam logic [7:0] HEAD_BYTE  = 8'h55;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam int unsigned FRAME_LEN = 11;
   localparam logic [3:0] IDX_LAST   = 4'(FRAME_LEN - 1);

   // item kinds, equal to the action codes
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_ZERO = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   // scaling and wrap
   localparam logic [14:0] SCALE_ACC   = 15'd16000;
   localparam logic [14:0] SCALE_ANGLE = 15'd18000;
   localparam logic signed [17:0] HALF_TURN = 18'sd18000;
   localparam logic signed [17:0] FULL_TURN = 18'sd36000;
   localparam logic signed [31:0] TRUNC_BIAS = 32'sd32767;

   // counters
   localparam logic [15:0] SAT16        = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_INIT = 16'd200;
   localparam logic [6:0]  ERR_PERIOD_M1 = 7'd99;

   localparam int ACC_W = 15;
   localparam int ANG_W = 16;

   // classified item passed from front to back
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       is_head;
      logic       is_ftype;
   } cmd_type;

   // queue push side
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   // queue head seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

endpackage

// ----- hdl/imufp_chan_if.sv -----
// valid/ready channel interfaces for request and response items
// depends on imufp_pkg for field widths
interface imufp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface imufp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [imufp_pkg::ANG_W-1:0]   roll_cd;
   logic signed [imufp_pkg::ANG_W-1:0]   pitch_cd;
   logic signed [imufp_pkg::ANG_W-1:0]   yaw_cd;
   logic signed [imufp_pkg::ACC_W-1:0]   acc_x_mg;
   logic signed [imufp_pkg::ACC_W-1:0]   acc_y_mg;
   logic signed [imufp_pkg::ACC_W-1:0]   acc_z_mg;
   logic [15:0]                          sample_seq;
   logic [15:0]                          rx_count;
   logic [15:0]                          angle_count;
   logic [15:0]                          error_count;
   logic                                 online;
   logic                                 valid_res;

   modport source (output valid, output roll_cd, output pitch_cd, output yaw_cd,
                   output acc_x_mg, output acc_y_mg, output acc_z_mg,
                   output sample_seq, output rx_count, output angle_count,
                   output error_count, output online, output valid_res,
                   input ready);
   modport sink   (input valid, input roll_cd, input pitch_cd, input yaw_cd,
                   input acc_x_mg, input acc_y_mg, input acc_z_mg,
                   input sample_seq, input rx_count, input angle_count,
                   input error_count, input online, input valid_res,
                   output ready);
endinterface

// ----- hdl/imufp_front.sv -----
// front end: accepts request items and classifies them for the back end
// depends on imufp_pkg and imufp_chan_if
module imufp_front (
   imufp_req_if.sink          req_chan,
   input  logic               q_full,
   output imufp_pkg::push_type push
);

   // take an item whenever the queue has room
   assign req_chan.ready = !q_full;

   // decode the byte against head and frame type codes
   always_comb begin
      push.valid        = req_chan.valid && !q_full;
      push.cmd.kind     = req_chan.action;
      push.cmd.data     = req_chan.rx_byte;
      push.cmd.is_head  = (req_chan.rx_byte == imufp_pkg::HEAD_BYTE);
      push.cmd.is_ftype = (req_chan.rx_byte == imufp_pkg::TYPE_ACC) ||
                          (req_chan.rx_byte == imufp_pkg::TYPE_GYRO) ||
                          (req_chan.rx_byte == imufp_pkg::TYPE_ANGLE);
   end

endmodule

// ----- hdl/imufp_queue.sv -----
// two-entry queue of classified items between front and back end
// depends on imufp_pkg
module imufp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  imufp_pkg::push_type  push,
   input  logic                 pop,
   output logic                 q_full,
   output imufp_pkg::qhead_type head
);

   imufp_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full     = (count_ff == 2'd2);
   assign do_push    = push.valid && !q_full;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ----- hdl/imufp_back.sv -----
// back end: frame hunt, running checksum, scaling, ageing, yaw zero and the snapshot
// depends on imufp_pkg and imufp_chan_if; the snapshot registers drive rsp
module imufp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [15:0]          csr_wdata,
   input  imufp_pkg::qhead_type head,
   output logic                 pop,
   imufp_rsp_if.source          rsp_chan
);

   // configuration
   logic [15:0] timeout_ff;

   // frame hunt state
   logic [3:0]         idx_ff, idx_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         lo_ff, lo_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [15:0] word_ff [3];
   logic signed [15:0] word_in [3];

   // ageing and zero
   logic [15:0]        age_ff, age_in;
   logic [6:0]         age_mod_ff, age_mod_in;
   logic signed [15:0] off_ff, off_in;
   logic               has_off_ff, has_off_in;

   // snapshot, doubles as the output register
   logic signed [15:0] roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic signed [14:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [15:0]        seq_ff, seq_in, rxc_ff, rxc_in;
   logic [15:0]        angc_ff, angc_in, errc_ff, errc_in;
   logic               online_ff, online_in, valid_ff, valid_in;
   logic               out_valid_ff, out_valid_in;

   // datapath helpers
   logic [14:0]        scale_k;
   logic signed [31:0] prod_new;
   logic signed [31:0] prod_biased;
   logic signed [15:0] prod_scaled;
   logic signed [17:0] yaw_diff;
   logic signed [17:0] yaw_wrap;
   logic [7:0]         b;

   assign b   = head.cmd.data;
   assign pop = head.valid && (!out_valid_ff || rsp_chan.ready);

   // one multiplier: raw word times the scale of this frame type
   always_comb begin
      scale_k  = (type_ff == imufp_pkg::TYPE_ACC) ? imufp_pkg::SCALE_ACC
                                                  : imufp_pkg::SCALE_ANGLE;
      prod_new = $signed({b, lo_ff}) * $signed({1'b0, scale_k});
   end

   // divide the held product by 32768, truncated toward zero
   always_comb begin
      prod_biased = prod_ff + (prod_ff[31] ? imufp_pkg::TRUNC_BIAS : 32'sd0);
      prod_scaled = prod_biased[30:15];
   end

   // yaw relative to the captured zero, wrapped once
   always_comb begin
      yaw_diff = {{2{word_ff[2][15]}}, word_ff[2]} - {{2{off_ff[15]}}, off_ff};
      if (yaw_diff > imufp_pkg::HALF_TURN) begin
         yaw_wrap = yaw_diff - imufp_pkg::FULL_TURN;
      end else if (yaw_diff < -imufp_pkg::HALF_TURN) begin
         yaw_wrap = yaw_diff + imufp_pkg::FULL_TURN;
      end else begin
         yaw_wrap = yaw_diff;
      end
   end

   // item execution
   always_comb begin
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      type_in    = type_ff;
      lo_in      = lo_ff;
      prod_in    = prod_ff;
      word_in    = word_ff;
      age_in     = age_ff;
      age_mod_in = age_mod_ff;
      off_in     = off_ff;
      has_off_in = has_off_ff;
      roll_in    = roll_ff;
      pitch_in   = pitch_ff;
      yaw_in     = yaw_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      az_in      = az_ff;
      seq_in     = seq_ff;
      rxc_in     = rxc_ff;
      angc_in    = angc_ff;
      errc_in    = errc_ff;
      online_in  = online_ff;
      valid_in   = valid_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;

      if (pop) begin
         out_valid_in = 1'b1;
         unique case (head.cmd.kind)
            imufp_pkg::KIND_BYTE: begin
               if (rxc_ff != imufp_pkg::SAT16) begin
                  rxc_in = rxc_ff + 16'd1;
               end
               priority if (idx_ff == 4'd0) begin
                  // hunting for a head byte
                  if (head.cmd.is_head) begin
                     sum_in = b;
                     idx_in = 4'd1;
                  end
               end else if (idx_ff == 4'd1 && !head.cmd.is_ftype) begin
                  // bad type: restart, the byte may be a new head
                  idx_in = head.cmd.is_head ? 4'd1 : 4'd0;
                  if (head.cmd.is_head) begin
                     sum_in = b;
                  end
               end else if (idx_ff > imufp_pkg::IDX_LAST) begin
                  idx_in = 4'd0;
               end else if (idx_ff == imufp_pkg::IDX_LAST) begin
                  // checksum byte closes the frame
                  idx_in = 4'd0;
                  if (sum_ff != b) begin
                     if (errc_ff != imufp_pkg::SAT16) begin
                        errc_in = errc_ff + 16'd1;
                     end
                  end else if (type_ff == imufp_pkg::TYPE_ACC) begin
                     ax_in = word_ff[0][14:0];
                     ay_in = word_ff[1][14:0];
                     az_in = word_ff[2][14:0];
                  end else if (type_ff == imufp_pkg::TYPE_ANGLE) begin
                     roll_in  = word_ff[0];
                     pitch_in = word_ff[1];
                     yaw_in   = has_off_ff ? yaw_wrap[15:0] : word_ff[2];
                     seq_in   = seq_ff + 16'd1;
                     if (angc_ff != imufp_pkg::SAT16) begin
                        angc_in = angc_ff + 16'd1;
                     end
                     online_in  = 1'b1;
                     valid_in   = 1'b1;
                     age_in     = 16'd0;
                     age_mod_in = 7'd0;
                  end
               end else begin
                  // type or data byte
                  sum_in = sum_ff + b;
                  idx_in = idx_ff + 4'd1;
                  unique case (idx_ff)
                     4'd1: type_in = b;
                     4'd2, 4'd4, 4'd6: lo_in = b;
                     4'd3, 4'd5, 4'd7: prod_in = prod_new;
                     default: ;
                  endcase
                  // finish the scaling one byte after the product
                  unique case (idx_ff)
                     4'd4: word_in[0] = prod_scaled;
                     4'd6: word_in[1] = prod_scaled;
                     4'd8: word_in[2] = prod_scaled;
                     default: ;
                  endcase
               end
            end
            imufp_pkg::KIND_TICK: begin
               if (age_ff != imufp_pkg::SAT16) begin
                  age_in     = age_ff + 16'd1;
                  age_mod_in = (age_mod_ff == imufp_pkg::ERR_PERIOD_M1) ? 7'd0
                                                                        : age_mod_ff + 7'd1;
               end
               if (age_in >= timeout_ff) begin
                  valid_in = 1'b0;
                  if (age_mod_in == 7'd0 && errc_ff != imufp_pkg::SAT16) begin
                     errc_in = errc_ff + 16'd1;
                  end
               end
            end
            imufp_pkg::KIND_ZERO: begin
               if (valid_ff) begin
                  off_in     = yaw_ff;
                  has_off_in = 1'b1;
               end
            end
            imufp_pkg::KIND_NONE: ;
            default: ;
         endcase
      end
   end

   // control and snapshot registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= imufp_pkg::TIMEOUT_INIT;
         idx_ff       <= 4'd0;
         sum_ff       <= 8'd0;
         age_ff       <= imufp_pkg::TIMEOUT_INIT;
         age_mod_ff   <= 7'd0;
         off_ff       <= 16'sd0;
         has_off_ff   <= 1'b0;
         roll_ff      <= 16'sd0;
         pitch_ff     <= 16'sd0;
         yaw_ff       <= 16'sd0;
         ax_ff        <= 15'sd0;
         ay_ff        <= 15'sd0;
         az_ff        <= 15'sd0;
         seq_ff       <= 16'd0;
         rxc_ff       <= 16'd0;
         angc_ff      <= 16'd0;
         errc_ff      <= 16'd0;
         online_ff    <= 1'b0;
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         age_ff       <= age_in;
         age_mod_ff   <= age_mod_in;
         off_ff       <= off_in;
         has_off_ff   <= has_off_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         az_ff        <= az_in;
         seq_ff       <= seq_in;
         rxc_ff       <= rxc_in;
         angc_ff      <= angc_in;
         errc_ff      <= errc_in;
         online_ff    <= online_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // frame payload, only read after the same frame wrote it
   always_ff @(posedge clock) begin
      type_ff <= type_in;
      lo_ff   <= lo_in;
      prod_ff <= prod_in;
      word_ff <= word_in;
   end

   // response channel
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.roll_cd     = roll_ff;
   assign rsp_chan.pitch_cd    = pitch_ff;
   assign rsp_chan.yaw_cd      = yaw_ff;
   assign rsp_chan.acc_x_mg    = ax_ff;
   assign rsp_chan.acc_y_mg    = ay_ff;
   assign rsp_chan.acc_z_mg    = az_ff;
   assign rsp_chan.sample_seq  = seq_ff;
   assign rsp_chan.rx_count    = rxc_ff;
   assign rsp_chan.angle_count = angc_ff;
   assign rsp_chan.error_count = errc_ff;
   assign rsp_chan.online      = online_ff;
   assign rsp_chan.valid_res   = valid_ff;

endmodule

// ----- hdl/imu_uart_frame_parser_top.sv -----
// imu uart frame parser: one result item for every accepted request item
// path: each accepted item is stored in the queue, then the back end registers its result
// throughput: one item per cycle while the response side keeps ready high
// the front end stalls only when the two-entry queue is full
// reset: synchronous, active high; snapshot cleared, age and timeout set to 200
// no clearing pass, the frame bytes need none
`include "imu_uart_frame_parser_top_macros.svh"

module imu_uart_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   imufp_req_if.sink   req_chan,
   imufp_rsp_if.source rsp_chan
);

   imufp_pkg::push_type  push;
   imufp_pkg::qhead_type head;
   logic                 q_full;
   logic                 pop;

   // classify incoming items
   imufp_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   // decouple front from back
   imufp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .q_full (q_full),
      .head   (head)
   );

   // carry out items and hold the snapshot
   imufp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .head      (head),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   // no good angle frame yet means no angle counts
   `IMUFP_ASSERT_IMPL(a_offline_counts, clock, reset, rsp_chan.valid && !rsp_chan.online,
                      rsp_chan.angle_count == 16'd0 && rsp_chan.sample_seq == 16'd0)
   // fresh data needs a frame to have arrived
   `IMUFP_ASSERT_IMPL(a_fresh_online, clock, reset, rsp_chan.valid && rsp_chan.valid_res,
                      rsp_chan.online)
   // the back end never pops an empty queue
   `IMUFP_ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, head.valid)
   // no result leaves right after reset
   `IMUFP_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_chan.valid)

endmodule
